// ===== sv/signed_decimal_ascii_formatter_assert.svh =====
// Assertion macros for the signed decimal ASCII formatter.
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SDAF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdaf assertion failed");
// Next-cycle implication.
`define SDAF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdaf assertion failed");
`else
`define SDAF_ASSERT_IMP(name, clk, rst, ante, cons)
`define SDAF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sdaf_pkg.sv =====
// Shared types, constants and the power-of-ten table of the formatter.
`timescale 1ns / 1ps
`default_nettype none
package sdaf_pkg;

   localparam int VALUE_W     = 32;
   localparam int FRACT_W     = 4;
   localparam int CHAR_W      = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FRACT_W-1:0] MAX_FRACT = 4'd9;
   localparam logic [FRACT_W-1:0] TOP_POS   = 4'd9;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
   localparam logic [2:0]        CHAR_DIGIT_HI = 3'b011;

   // Classified word handed from front to back.
   typedef struct packed {
      logic                neg;
      logic [VALUE_W-1:0]  mag;
      logic [FRACT_W-1:0]  fract;
   } item_type;

   // 10^pos for the ten digit positions.
   function automatic logic [29:0] pow10(input logic [FRACT_W-1:0] pos);
      logic [29:0] r;
      case (pos)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         4'd9: r = 30'd1000000000;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/sdaf_front.sv =====
// Front stage: takes a word, forms sign, magnitude and clamped digit count.
`timescale 1ns / 1ps
`default_nettype none
module sdaf_front
   import sdaf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic [FRACT_W-1:0]         req_fract_digits,
   input  wire logic                       q_full,
   output logic                            q_push,
   output item_type                        q_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic [VALUE_W-1:0] raw;

   assign busy   = reset | (valid_ff & q_full);
   assign accept = start & ~busy;
   assign q_push = valid_ff & ~q_full;
   assign q_item = item_ff;

   // Classify: sign, unsigned magnitude, saturated fraction count
   always_comb begin
      raw          = VALUE_W'(req_value);
      item_in.neg  = raw[VALUE_W-1];
      item_in.mag  = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      item_in.fract = (req_fract_digits > MAX_FRACT) ? MAX_FRACT : req_fract_digits;
      valid_in     = accept | (valid_ff & ~q_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sdaf_fifo.sv =====
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sdaf_fifo
   import sdaf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire item_type  push_item,
   output logic           full,
   output logic           not_empty,
   input  wire logic      pop,
   output item_type       pop_item
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sdaf_back.sv =====
// Back stage: walks the digit positions and emits one character per slot.
`timescale 1ns / 1ps
`default_nettype none
module sdaf_back
   import sdaf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_not_empty,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   output logic [CHAR_W-1:0] rsp_character,
   output logic             rsp_last
);

   typedef enum logic [1:0] {ST_IDLE, ST_SIGN, ST_POINT, ST_DIGIT} state_type;

   state_type           state_ff;
   logic                neg_ff;
   logic [VALUE_W-1:0]  mag_ff;
   logic [FRACT_W-1:0]  fract_ff;
   logic [FRACT_W-1:0]  pos_ff;
   logic                printing_ff;
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic                rsp_last_ff;

   logic [29:0]         scale;
   logic [33:0]         thr [10];
   logic [3:0]          digit;
   logic                show;
   logic [FRACT_W-1:0]  pos_dn;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // Point goes in front of the digit at position fract - 1
   function automatic logic point_before(input logic [FRACT_W-1:0] p,
                                         input logic [FRACT_W-1:0] f);
      return (f != '0) && (p == f - 1'b1);
   endfunction

   // Digit of the current position: compare against the nine multiples
   always_comb begin
      scale = pow10(pos_ff);
      digit = '0;
      for (int k = 0; k < 10; k++) begin
         thr[k] = 34'(scale) * 34'(k);
      end
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, mag_ff} >= thr[k]) begin
            digit = 4'(k);
         end
      end
      show   = printing_ff | (digit != '0) | (pos_ff <= fract_ff);
      pos_dn = pos_ff - 1'b1;
   end

   // Next word taken when idle or on the units digit of the current one
   assign q_pop = q_not_empty &
                  ((state_ff == ST_IDLE) | ((state_ff == ST_DIGIT) & (pos_ff == '0)));

   // Sequencer with registered result outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         if (q_pop) begin
            neg_ff      <= q_item.neg;
            mag_ff      <= q_item.mag;
            fract_ff    <= q_item.fract;
            printing_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               rsp_valid_ff <= neg_ff;
               rsp_char_ff  <= CHAR_MINUS;
               pos_ff       <= TOP_POS;
               state_ff     <= point_before(TOP_POS, fract_ff) ? ST_POINT : ST_DIGIT;
            end
            ST_POINT: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= CHAR_POINT;
               state_ff     <= ST_DIGIT;
            end
            ST_DIGIT: begin
               rsp_valid_ff <= show;
               rsp_char_ff  <= {CHAR_DIGIT_HI, digit};
               rsp_last_ff  <= (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_ff <= q_pop ? ST_SIGN : ST_IDLE;
               end else begin
                  mag_ff      <= mag_ff - thr[digit][VALUE_W-1:0];
                  printing_ff <= show;
                  pos_ff      <= pos_dn;
                  state_ff    <= point_before(pos_dn, fract_ff) ? ST_POINT : ST_DIGIT;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/signed_decimal_ascii_formatter.sv =====
// Top level of the signed fixed-point decimal to ASCII formatter.
//
//   Channel   Ports                                     Handshake
//   request   req_value, req_fract_digits               start high while busy low
//   response  rsp_character, rsp_last                   rsp_valid strobe, one cycle
//
// Each word yields one character per cycle from the back sequencer: a sign slot,
// ten digit slots and a point slot when digits follow the point; suppressed
// characters use their slot. A word passes through the front register and the
// queue before it reaches the back; words stream without gaps. busy is high in reset
// and otherwise only while the front register and the two-word queue are full.
// Synchronous active-high reset empties front, queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_decimal_ascii_formatter_assert.svh"
module signed_decimal_ascii_formatter
   import sdaf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic [FRACT_W-1:0]         req_fract_digits,
   output logic                            rsp_valid,
   output logic [CHAR_W-1:0]               rsp_character,
   output logic                            rsp_last
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type push_item;
   item_type pop_item;
   logic     rsp_is_digit;
   logic     rsp_point;

   sdaf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_fract_digits (req_fract_digits),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   sdaf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_item  (pop_item)
   );

   sdaf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Character classes seen by the checks below
   assign rsp_is_digit = (rsp_character >= {CHAR_DIGIT_HI, 4'd0}) &&
                         (rsp_character <= {CHAR_DIGIT_HI, 4'd9});
   assign rsp_point    = rsp_valid && (rsp_character == CHAR_POINT);

   // The final character of a word is always a digit
   `SDAF_ASSERT_IMP(a_last_is_digit, clock, reset, rsp_valid && rsp_last, rsp_is_digit)
   // A point is always followed at once by a fraction digit
   `SDAF_ASSERT_NEXT(a_point_then_digit, clock, reset, rsp_point, rsp_valid && rsp_is_digit)
   // A minus sign never ends a word
   `SDAF_ASSERT_IMP(a_minus_not_last, clock, reset, rsp_valid && (rsp_character == CHAR_MINUS), !rsp_last)
   // Stall toward the requester outside reset only with the queue full
   `SDAF_ASSERT_IMP(a_busy_needs_full, clock, reset, busy && !reset, q_full)

endmodule
`default_nettype wire
